// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define MCSA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MCSA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/mcsa_pkg.sv
// ----------------------------------------------------------------------------
// mcsa_pkg
// Types and constants of the multi-crop score accumulator with argmax.
// ----------------------------------------------------------------------------
package mcsa_pkg;

    localparam int SCORE_W    = 8;
    localparam int LABEL_W    = 6;
    localparam int CLASS_W    = 6;
    localparam int SUM_W      = 12;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int CROPS_FIELD_W   = 5;
    localparam int CLASSES_FIELD_W = 7;

    localparam int MAX_CLASSES_DEFAULT = 64;
    localparam int MAX_CROPS_DEFAULT   = 16;

    localparam int CROPS_RESET   = 8;
    localparam int CLASSES_RESET = 64;

    localparam logic signed [SUM_W:0] SUM_MAX = 13'sd2047;
    localparam logic signed [SUM_W:0] SUM_MIN = -13'sd2048;
    localparam logic [COUNT_W-1:0]    COUNT_MAX = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CROPS_PER_CLIP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT    = 2'd1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [LABEL_W-1:0]        expected_label;
    } mcsa_in_t;

    typedef struct packed {
        logic [CLASS_W-1:0]      predicted_class;
        logic signed [SUM_W-1:0] winning_sum;
        logic                    hit;
        logic [COUNT_W-1:0]      hit_total;
        logic [COUNT_W-1:0]      clip_total;
    } mcsa_out_t;

endpackage

// File: hw/rtl/mcsa_sum_mem.sv
// ----------------------------------------------------------------------------
// mcsa_sum_mem
// Per-class sum store: one write port and one registered read port, with a
// bypass for a read of the address written in the same cycle.
// ----------------------------------------------------------------------------
module mcsa_sum_mem #(
    parameter int MAX_CLASSES = mcsa_pkg::MAX_CLASSES_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [$clog2(MAX_CLASSES)-1:0]    wr_addr,
    input  logic signed [mcsa_pkg::SUM_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(MAX_CLASSES)-1:0]    rd_addr,
    output logic signed [mcsa_pkg::SUM_W-1:0] rd_data
);

    logic signed [mcsa_pkg::SUM_W-1:0] mem_reg [MAX_CLASSES];
    logic signed [mcsa_pkg::SUM_W-1:0] rd_raw_reg;
    logic signed [mcsa_pkg::SUM_W-1:0] byp_data_reg;
    logic                              byp_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_raw_reg   <= mem_reg[rd_addr];
            byp_reg      <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_raw_reg;

endmodule

// File: hw/rtl/mcsa_core.sv
// ----------------------------------------------------------------------------
// mcsa_core
// Sum update, running argmax, clip counters and position tracking for one
// item per cycle while fire is high.
// ----------------------------------------------------------------------------
module mcsa_core #(
    parameter int MAX_CLASSES = mcsa_pkg::MAX_CLASSES_DEFAULT,
    parameter int MAX_CROPS   = mcsa_pkg::MAX_CROPS_DEFAULT,
    localparam int CLS_W      = $clog2(MAX_CLASSES),
    localparam int CLS_CNT_W  = $clog2(MAX_CLASSES + 1),
    localparam int CROP_W     = (MAX_CROPS > 1) ? $clog2(MAX_CROPS) : 1,
    localparam int CROP_CNT_W = $clog2(MAX_CROPS + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [CLS_CNT_W-1:0]              ncls,
    input  logic [CROP_CNT_W-1:0]             ncrop,
    input  logic                              fire,
    input  mcsa_pkg::mcsa_in_t                in_item,
    output logic                              produce,
    output mcsa_pkg::mcsa_out_t               result,
    output logic                              wr_en,
    output logic [CLS_W-1:0]                  wr_addr,
    output logic signed [mcsa_pkg::SUM_W-1:0] wr_data,
    output logic                              rd_en,
    output logic [CLS_W-1:0]                  rd_addr,
    input  logic signed [mcsa_pkg::SUM_W-1:0] rd_data
);

    logic [CLS_W-1:0]                  class_pos_reg, class_pos_next;
    logic [CROP_W-1:0]                 crop_pos_reg, crop_pos_next;
    logic signed [mcsa_pkg::SUM_W-1:0] best_sum_reg, best_sum_next;
    logic [CLS_W-1:0]                  best_class_reg, best_class_next;
    logic [mcsa_pkg::COUNT_W-1:0]      hits_reg, hits_next;
    logic [mcsa_pkg::COUNT_W-1:0]      clips_reg, clips_next;

    logic                              last_class;
    logic                              last_crop;
    logic                              hit;
    logic signed [mcsa_pkg::SUM_W-1:0] score_ext;
    logic signed [mcsa_pkg::SUM_W:0]   raw_sum;
    logic signed [mcsa_pkg::SUM_W-1:0] sum;

    assign last_class = (32'(class_pos_reg) + 32'd1) >= 32'(ncls);
    assign last_crop  = (32'(crop_pos_reg) + 32'd1) >= 32'(ncrop);
    assign produce    = last_class && last_crop;

    assign score_ext = mcsa_pkg::SUM_W'(in_item.score);
    assign raw_sum   = (mcsa_pkg::SUM_W + 1)'(rd_data) + (mcsa_pkg::SUM_W + 1)'(score_ext);

    always_comb begin
        if (crop_pos_reg == '0) begin
            sum = score_ext;
        end else if (raw_sum > mcsa_pkg::SUM_MAX) begin
            sum = mcsa_pkg::SUM_W'(mcsa_pkg::SUM_MAX);
        end else if (raw_sum < mcsa_pkg::SUM_MIN) begin
            sum = mcsa_pkg::SUM_W'(mcsa_pkg::SUM_MIN);
        end else begin
            sum = mcsa_pkg::SUM_W'(raw_sum);
        end
    end

    always_comb begin
        best_sum_next   = best_sum_reg;
        best_class_next = best_class_reg;
        // The first class of the last crop always seeds the argmax.
        if (last_crop && ((class_pos_reg == '0) || (sum > best_sum_reg))) begin
            best_sum_next   = sum;
            best_class_next = class_pos_reg;
        end
    end

    assign hit = 32'(best_class_next) == 32'(in_item.expected_label);

    always_comb begin
        hits_next  = hits_reg;
        clips_next = clips_reg;
        if (produce) begin
            if (hit && (hits_reg != mcsa_pkg::COUNT_MAX)) begin
                hits_next = hits_reg + 1'b1;
            end
            if (clips_reg != mcsa_pkg::COUNT_MAX) begin
                clips_next = clips_reg + 1'b1;
            end
        end
    end

    always_comb begin
        class_pos_next = class_pos_reg + 1'b1;
        crop_pos_next  = crop_pos_reg;
        if (last_class) begin
            class_pos_next = '0;
            crop_pos_next  = last_crop ? '0 : crop_pos_reg + 1'b1;
        end
    end

    always_comb begin
        result.predicted_class = mcsa_pkg::CLASS_W'(best_class_next);
        result.winning_sum     = best_sum_next;
        result.hit             = hit;
        result.hit_total       = hits_next;
        result.clip_total      = clips_next;
    end

    // The read for the next item is issued as this one retires.
    assign wr_en   = fire;
    assign wr_addr = class_pos_reg;
    assign wr_data = sum;
    assign rd_en   = fire;
    assign rd_addr = class_pos_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_pos_reg  <= '0;
            crop_pos_reg   <= '0;
            best_sum_reg   <= '0;
            best_class_reg <= '0;
            hits_reg       <= '0;
            clips_reg      <= '0;
        end else if (fire) begin
            class_pos_reg  <= class_pos_next;
            crop_pos_reg   <= crop_pos_next;
            best_sum_reg   <= best_sum_next;
            best_class_reg <= best_class_next;
            hits_reg       <= hits_next;
            clips_reg      <= clips_next;
        end
    end

endmodule

// File: hw/rtl/multi_crop_score_argmax.sv
// ----------------------------------------------------------------------------
// multi_crop_score_argmax
// Sums class scores over crops and reports the winning class of each clip.
// ----------------------------------------------------------------------------
// The block takes one score item per cycle, sustained while no closing item
// waits for room on the output side, and gives one result item at the last
// class of the last crop of each clip. An accepted item is held in the input
// register until it is processed; its result, if any, is then loaded into the
// output register, which drives m_valid. Only a closing item waits for room
// on the output side; any other item passes through the input register
// whatever m_ready does. The rate is set by the per-class sum store, which
// takes one write and one read of the next class position in each cycle in
// which an item is processed; the read is prefetched and bypassed when it
// hits the address just written. The store is MAX_CLASSES entries
// of 12 bits with no reset and no clearing pass: the first crop of each clip
// overwrites it. Configuration values are clamped to their legal range when
// written.
module multi_crop_score_argmax #(
    parameter int MAX_CLASSES = mcsa_pkg::MAX_CLASSES_DEFAULT,
    parameter int MAX_CROPS   = mcsa_pkg::MAX_CROPS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mcsa_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [mcsa_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  mcsa_pkg::mcsa_in_t                 s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output mcsa_pkg::mcsa_out_t                m_item
);

    localparam int CLS_W      = $clog2(MAX_CLASSES);
    localparam int CLS_CNT_W  = $clog2(MAX_CLASSES + 1);
    localparam int CROP_CNT_W = $clog2(MAX_CROPS + 1);
    localparam int NCROP_RST  =
        (mcsa_pkg::CROPS_RESET > MAX_CROPS) ? MAX_CROPS : mcsa_pkg::CROPS_RESET;
    localparam int NCLS_RST   =
        (mcsa_pkg::CLASSES_RESET > MAX_CLASSES) ? MAX_CLASSES : mcsa_pkg::CLASSES_RESET;

    logic [CLS_CNT_W-1:0]  ncls_reg;
    logic [CROP_CNT_W-1:0] ncrop_reg;
    logic [CLS_CNT_W-1:0]  ncls_wr;
    logic [CROP_CNT_W-1:0] ncrop_wr;

    logic [mcsa_pkg::CROPS_FIELD_W-1:0]   crops_field;
    logic [mcsa_pkg::CLASSES_FIELD_W-1:0] classes_field;

    logic                 in_valid_reg;
    mcsa_pkg::mcsa_in_t   in_item_reg;
    logic                 out_valid_reg;
    mcsa_pkg::mcsa_out_t  out_item_reg;

    logic                 fire;
    logic                 produce;
    mcsa_pkg::mcsa_out_t  result;

    logic                              wr_en;
    logic [CLS_W-1:0]                  wr_addr;
    logic signed [mcsa_pkg::SUM_W-1:0] wr_data;
    logic                              rd_en;
    logic [CLS_W-1:0]                  rd_addr;
    logic signed [mcsa_pkg::SUM_W-1:0] rd_data;

    // Configuration values are stored already clamped.
    assign crops_field   = cfg_wr_data[mcsa_pkg::CROPS_FIELD_W-1:0];
    assign classes_field = cfg_wr_data[mcsa_pkg::CLASSES_FIELD_W-1:0];

    always_comb begin
        if (crops_field == '0) begin
            ncrop_wr = CROP_CNT_W'(1);
        end else if (32'(crops_field) > 32'(MAX_CROPS)) begin
            ncrop_wr = CROP_CNT_W'(MAX_CROPS);
        end else begin
            ncrop_wr = CROP_CNT_W'(crops_field);
        end
        if (classes_field == '0) begin
            ncls_wr = CLS_CNT_W'(1);
        end else if (32'(classes_field) > 32'(MAX_CLASSES)) begin
            ncls_wr = CLS_CNT_W'(MAX_CLASSES);
        end else begin
            ncls_wr = CLS_CNT_W'(classes_field);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncrop_reg <= CROP_CNT_W'(NCROP_RST);
            ncls_reg  <= CLS_CNT_W'(NCLS_RST);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                mcsa_pkg::REG_CROPS_PER_CLIP: ncrop_reg <= ncrop_wr;
                mcsa_pkg::REG_CLASS_COUNT:    ncls_reg  <= ncls_wr;
                default: ;
            endcase
        end
    end

    // An item that closes no clip needs no room on the output side.
    assign fire    = in_valid_reg && (!produce || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && produce) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && produce) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    mcsa_core #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_CROPS   (MAX_CROPS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ncls    (ncls_reg),
        .ncrop   (ncrop_reg),
        .fire    (fire),
        .in_item (in_item_reg),
        .produce (produce),
        .result  (result),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mcsa_sum_mem #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_sum_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// File: hw/rtl/mcsa_checker.sv
// ----------------------------------------------------------------------------
// mcsa_checker
// Port-level checks of the multi-crop score accumulator, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcsa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input mcsa_pkg::mcsa_in_t              s_item,
    input logic                            m_valid,
    input logic                            m_ready,
    input mcsa_pkg::mcsa_out_t             m_item
);

    // A waiting input item keeps its payload.
    `MCSA_ASSERT(a_in_hold, aclk, aresetn, s_valid && !s_ready |=> s_valid && $stable(s_item), "input item changed while waiting")

    // A stalled result item keeps its payload.
    `MCSA_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_item), "result item changed while stalled")

    // Reset empties both the input and the output registers.
    `MCSA_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready, "block not empty after reset")

    // Every result counts its own clip, and hits never outnumber clips.
    `MCSA_ASSERT(a_counts, aclk, aresetn, m_valid |-> (m_item.clip_total != '0) && (m_item.hit_total <= m_item.clip_total), "inconsistent clip counters")

    // A hit is always reflected in the hit count.
    `MCSA_ASSERT(a_hit_count, aclk, aresetn, m_valid && m_item.hit |-> m_item.hit_total != '0, "hit not counted")

endmodule

bind multi_crop_score_argmax mcsa_checker u_mcsa_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives score items through multi_crop_score_argmax under several crop and
// class settings and checks every clip decision against a predictor of the
// accumulation, the running argmax and the saturating hit and clip counts.
// ----------------------------------------------------------------------------
module testbench;

    localparam int N_CLASSES = mcsa_pkg::MAX_CLASSES_DEFAULT;
    localparam int N_CROPS   = mcsa_pkg::MAX_CROPS_DEFAULT;

    // Keeps its own copy of the accumulator state and holds the decisions
    // still owed by the block, oldest first.
    class clip_ledger;
        logic [mcsa_pkg::CROPS_FIELD_W-1:0]   crop_reg;
        logic [mcsa_pkg::CLASSES_FIELD_W-1:0] class_reg;
        int                  sums [N_CLASSES];
        int                  class_pos;
        int                  crop_pos;
        int                  best_sum;
        int                  best_class;
        int                  hits;
        int                  clips;
        int                  faults;
        int                  seen;
        mcsa_pkg::mcsa_out_t owed_decisions [$];

        function new();
            crop_reg   = mcsa_pkg::CROPS_FIELD_W'(mcsa_pkg::CROPS_RESET);
            class_reg  = mcsa_pkg::CLASSES_FIELD_W'(mcsa_pkg::CLASSES_RESET);
            foreach (sums[i]) sums[i] = 0;
            class_pos  = 0;
            crop_pos   = 0;
            best_sum   = 0;
            best_class = 0;
            hits       = 0;
            clips      = 0;
            faults     = 0;
            seen       = 0;
        endfunction

        function void write_reg(logic [mcsa_pkg::CFG_IDX_W-1:0] idx,
                                logic [mcsa_pkg::CFG_DATA_W-1:0] data);
            if (idx == mcsa_pkg::REG_CROPS_PER_CLIP)
                crop_reg = data[mcsa_pkg::CROPS_FIELD_W-1:0];
            else if (idx == mcsa_pkg::REG_CLASS_COUNT)
                class_reg = data[mcsa_pkg::CLASSES_FIELD_W-1:0];
        endfunction

        function int waiting();
            return owed_decisions.size();
        endfunction

        function void note_score(mcsa_pkg::mcsa_in_t it);
            int                  s;
            int                  ncls;
            int                  ncrop;
            int                  idx;
            int                  sum;
            bit                  last_class;
            bit                  last_crop;
            bit                  hit_now;
            mcsa_pkg::mcsa_out_t d;
            s     = $signed(it.score);
            ncls  = (class_reg < 1) ? 1 : ((class_reg > N_CLASSES) ? N_CLASSES : class_reg);
            ncrop = (crop_reg < 1) ? 1 : ((crop_reg > N_CROPS) ? N_CROPS : crop_reg);
            idx   = class_pos % N_CLASSES;
            last_class = (class_pos + 1 >= ncls);
            last_crop  = (crop_pos + 1 >= ncrop);
            if (crop_pos == 0) begin
                sum = s;
            end else begin
                sum = sums[idx] + s;
                if (sum > 2047) sum = 2047;
                if (sum < -2048) sum = -2048;
            end
            sums[idx] = sum;
            if (last_crop && (class_pos == 0 || sum > best_sum)) begin
                best_sum   = sum;
                best_class = idx;
            end
            if (last_class) begin
                class_pos = 0;
                if (last_crop) begin
                    hit_now = (best_class == it.expected_label);
                    if (hit_now && hits < mcsa_pkg::COUNT_MAX) hits++;
                    if (clips < mcsa_pkg::COUNT_MAX) clips++;
                    d.predicted_class = best_class[mcsa_pkg::CLASS_W-1:0];
                    d.winning_sum     = best_sum[mcsa_pkg::SUM_W-1:0];
                    d.hit             = hit_now;
                    d.hit_total       = hits[mcsa_pkg::COUNT_W-1:0];
                    d.clip_total      = clips[mcsa_pkg::COUNT_W-1:0];
                    owed_decisions.push_back(d);
                    crop_pos = 0;
                end else begin
                    crop_pos++;
                end
            end else begin
                class_pos++;
            end
        endfunction

        function void check_decision(mcsa_pkg::mcsa_out_t got);
            mcsa_pkg::mcsa_out_t want;
            seen++;
            if (owed_decisions.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected decision: class %0d sum %0d hit %0d hits %0d clips %0d",
                             got.predicted_class, $signed(got.winning_sum), got.hit,
                             got.hit_total, got.clip_total);
                return;
            end
            want = owed_decisions.pop_front();
            if (got.predicted_class !== want.predicted_class ||
                got.winning_sum !== want.winning_sum || got.hit !== want.hit ||
                got.hit_total !== want.hit_total || got.clip_total !== want.clip_total) begin
                faults++;
                if (faults <= 10) begin
                    $display("decision mismatch: expected class %0d sum %0d hit %0d hits %0d clips %0d",
                             want.predicted_class, $signed(want.winning_sum), want.hit,
                             want.hit_total, want.clip_total);
                    $display("                   actual   class %0d sum %0d hit %0d hits %0d clips %0d",
                             got.predicted_class, $signed(got.winning_sum), got.hit,
                             got.hit_total, got.clip_total);
                end
            end
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [mcsa_pkg::CFG_IDX_W-1:0]  cfg_wr_index;
    logic [mcsa_pkg::CFG_DATA_W-1:0] cfg_wr_data;
    logic                            s_valid;
    logic                            s_ready;
    mcsa_pkg::mcsa_in_t              s_item;
    logic                            m_valid;
    logic                            m_ready;
    mcsa_pkg::mcsa_out_t             m_item;

    clip_ledger ledger;
    int         burst_left = 0;
    int         items_sent = 0;
    logic [9:0] rx_tick = '0;

    int ext_crops [5]   = '{31, 16, 1, 2, 0};
    int ext_classes [5] = '{1, 3, 127, 64, 0};

    multi_crop_score_argmax u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The receiver steps through four stall behaviours, chosen by rx_tick[9:8].
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) ledger.check_decision(m_item);
        rx_tick <= rx_tick + 1'b1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            case (rx_tick[9:8])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= 1'($urandom_range(0, 1));
                2'd2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (rx_tick[3:0] < 4'd11);
            endcase
        end
    end

    // Sends one item, opening a fresh burst after a random gap when the
    // current burst is used up.
    task automatic push_item(input mcsa_pkg::mcsa_in_t it);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        ledger.note_score(it);
        burst_left--;
        items_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (ledger.waiting() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_config(input int crops, input int classes);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= mcsa_pkg::REG_CROPS_PER_CLIP;
        cfg_wr_data  <= crops[mcsa_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_index <= mcsa_pkg::REG_CLASS_COUNT;
        cfg_wr_data  <= classes[mcsa_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ledger.write_reg(mcsa_pkg::REG_CROPS_PER_CLIP, crops[mcsa_pkg::CFG_DATA_W-1:0]);
        ledger.write_reg(mcsa_pkg::REG_CLASS_COUNT, classes[mcsa_pkg::CFG_DATA_W-1:0]);
    endtask

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        mcsa_pkg::mcsa_in_t it;
        int                 p;
        int                 crops;
        int                 classes;
        int                 ncrop;
        int                 ncls;
        int                 nclip;
        int                 style;
        logic signed [7:0]  level;
        ledger       = new();
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= mcsa_pkg::REG_CROPS_PER_CLIP;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_item       <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // One class per clip: every item is a decision.
        set_config(1, 1);
        it = '{score: 8'sd127, expected_label: 6'd0};    push_item(it);
        it = '{score: -8'sd128, expected_label: 6'd63};  push_item(it);
        it = '{score: 8'sd0, expected_label: 6'd0};      push_item(it);
        it = '{score: -8'sd1, expected_label: 6'd1};     push_item(it);
        // Zero in both registers clamps to one crop of one class.
        settle();
        set_config(0, 0);
        it = '{score: 8'sd5, expected_label: 6'd0};      push_item(it);
        it = '{score: -8'sd5, expected_label: 6'd42};    push_item(it);
        // Equal scores: the lowest class wins; then a lone maximum.
        settle();
        set_config(1, 4);
        repeat (4) begin
            it = '{score: 8'sd3, expected_label: 6'd0};  push_item(it);
        end
        it = '{score: -8'sd128, expected_label: 6'd21};  push_item(it);
        it = '{score: -8'sd128, expected_label: 6'd21};  push_item(it);
        it = '{score: -8'sd127, expected_label: 6'd21};  push_item(it);
        it = '{score: -8'sd128, expected_label: 6'd2};   push_item(it);

        // The first few settings are the extremes; the rest are random with
        // a bias towards small clips.
        p = 0;
        while (p < 5 || items_sent < 720 || ledger.seen < 48) begin
            if (p < 5) begin
                crops   = ext_crops[p];
                classes = ext_classes[p];
            end else begin
                crops   = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                                     : $urandom_range(0, 31);
                classes = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                     : $urandom_range(0, 127);
            end
            settle();
            set_config(crops, classes);
            ncrop = (crops < 1) ? 1 : ((crops > N_CROPS) ? N_CROPS : crops);
            ncls  = (classes < 1) ? 1 : ((classes > N_CLASSES) ? N_CLASSES : classes);
            nclip = 60 / (ncrop * ncls);
            if (nclip < 1) nclip = 1;
            if (nclip > 10) nclip = 10;
            repeat (nclip) begin
                style = $urandom_range(0, 3);
                case ($urandom_range(0, 2))
                    0: level = -8'sd128;
                    1: level = 8'sd127;
                    default: level = 8'($urandom_range(0, 255));
                endcase
                for (int c = 0; c < ncrop; c++) begin
                    for (int k = 0; k < ncls; k++) begin
                        case (style)
                            0: it.score = 8'($urandom_range(0, 255));
                            1: it.score = 8'($urandom_range(0, 6) - 3);
                            2: begin
                                case ($urandom_range(0, 3))
                                    0: it.score = -8'sd128;
                                    1: it.score = 8'sd127;
                                    2: it.score = 8'sd0;
                                    default: it.score = -8'sd1;
                                endcase
                            end
                            default: it.score = level;
                        endcase
                        it.expected_label = $urandom_range(0, 1)
                                            ? 6'($urandom_range(0, ncls - 1))
                                            : 6'($urandom_range(0, 63));
                        push_item(it);
                    end
                end
            end
            p++;
        end

        settle();
        repeat (10) @(posedge aclk);
        if (ledger.faults == 0 && ledger.waiting() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mcsa_pkg.sv
hw/rtl/mcsa_sum_mem.sv
hw/rtl/mcsa_core.sv
hw/rtl/multi_crop_score_argmax.sv
hw/rtl/mcsa_checker.sv
verif/testbench.sv
